>>> rtl/stable_priority_queue_with_upgrade_assert.svh
// ----------------------------------------------------------------------------
// stable_priority_queue_with_upgrade_assert.svh
// assertion macros used by the priority queue top module
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_WITH_UPGRADE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_WITH_UPGRADE_ASSERT_SVH

// a condition that holds at every edge outside reset
`define SPQ_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent in the same cycle as the antecedent
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the cycle after the antecedent
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// shared codes, widths and types of the priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

	// default sizes
	localparam int DEF_CAPACITY      = 64;
	localparam int DEF_ID_BITS       = 16;
	localparam int DEF_PRIORITY_BITS = 16;

	// port field widths
	localparam int FIELD_W   = 16;
	localparam int CMD_W     = 2;
	localparam int QCOUNT_W  = 7;
	localparam int STATUS_W  = 3;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 64;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UPGRADE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_URGENT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ABSENT     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

	// per-cycle control broadcast along the cell row
	typedef struct packed {
		logic insert;     // place the key entry in sorted position
		logic remove;     // close the gap from the first matching cell on
		logic remove_all; // shift every cell towards the front
	} spq_ctl_t;

endpackage

>>> rtl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted row: holds an entry, compares it with the key
// and keeps its own entry or takes the key, its left or its right neighbour's entry
// ----------------------------------------------------------------------------
module spq_cell #(
	parameter int ID_BITS       = spq_pkg::DEF_ID_BITS,
	parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
	parameter int CNT_W         = 7,
	parameter int IDX           = 0
) (
	input  logic                     clk,
	input  spq_pkg::spq_ctl_t        ctl,
	input  logic [ID_BITS-1:0]       key_id,
	input  logic [PRIORITY_BITS-1:0] key_pri,
	input  logic [PRIORITY_BITS-1:0] key_old,
	input  logic [CNT_W-1:0]         count,
	input  logic [ID_BITS-1:0]       left_id,
	input  logic [PRIORITY_BITS-1:0] left_pri,
	input  logic                     left_le,
	input  logic [ID_BITS-1:0]       right_id,
	input  logic [PRIORITY_BITS-1:0] right_pri,
	input  logic                     seen_in,
	output logic [ID_BITS-1:0]       id,
	output logic [PRIORITY_BITS-1:0] pri,
	output logic                     le,
	output logic                     seen_out
);

	logic [ID_BITS-1:0]       id_q;
	logic [PRIORITY_BITS-1:0] pri_q;
	logic                     valid;
	logic                     match;

	// slot is in use when it lies below the fill count
	assign valid    = count > CNT_W'(IDX);
	assign le       = valid && (pri_q <= key_pri);
	assign match    = valid && (id_q == key_id) && (pri_q == key_old);
	assign seen_out = seen_in | match;

	assign id  = id_q;
	assign pri = pri_q;

	// entry update: keep, take the new entry, shift back or shift forward
	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (!le) begin
				if (left_le) begin
					id_q  <= key_id;
					pri_q <= key_pri;
				end else begin
					id_q  <= left_id;
					pri_q <= left_pri;
				end
			end
		end else if (ctl.remove_all || (ctl.remove && seen_out)) begin
			id_q  <= right_id;
			pri_q <= right_pri;
		end
	end

endmodule

>>> rtl/spq_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_chain
// the row of cells, wired neighbour to neighbour, front at cell zero
// ----------------------------------------------------------------------------
module spq_chain #(
	parameter int CAPACITY      = spq_pkg::DEF_CAPACITY,
	parameter int ID_BITS       = spq_pkg::DEF_ID_BITS,
	parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
	parameter int CNT_W         = 7
) (
	input  logic                     clk,
	input  spq_pkg::spq_ctl_t        ctl,
	input  logic [ID_BITS-1:0]       key_id,
	input  logic [PRIORITY_BITS-1:0] key_pri,
	input  logic [PRIORITY_BITS-1:0] key_old,
	input  logic [CNT_W-1:0]         count,
	output logic [ID_BITS-1:0]       front_id,
	output logic [PRIORITY_BITS-1:0] front_pri,
	output logic                     found
);

	logic [ID_BITS-1:0]       c_id   [CAPACITY];
	logic [PRIORITY_BITS-1:0] c_pri  [CAPACITY];
	logic                     c_le   [CAPACITY];
	logic                     c_seen [CAPACITY];

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic [ID_BITS-1:0]       l_id;
			logic [PRIORITY_BITS-1:0] l_pri;
			logic                     l_le;
			logic                     l_seen;
			logic [ID_BITS-1:0]       r_id;
			logic [PRIORITY_BITS-1:0] r_pri;

			// left side: the front cell sees an always-smaller neighbour
			if (i == 0) begin : g_front
				assign l_id   = key_id;
				assign l_pri  = key_pri;
				assign l_le   = 1'b1;
				assign l_seen = 1'b0;
			end else begin : g_inner
				assign l_id   = c_id[i-1];
				assign l_pri  = c_pri[i-1];
				assign l_le   = c_le[i-1];
				assign l_seen = c_seen[i-1];
			end

			// right side: the tail cell refills from itself
			if (i == CAPACITY - 1) begin : g_tail
				assign r_id  = c_id[i];
				assign r_pri = c_pri[i];
			end else begin : g_body
				assign r_id  = c_id[i+1];
				assign r_pri = c_pri[i+1];
			end

			spq_cell #(
				.ID_BITS      (ID_BITS),
				.PRIORITY_BITS(PRIORITY_BITS),
				.CNT_W        (CNT_W),
				.IDX          (i)
			) u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.key_id   (key_id),
				.key_pri  (key_pri),
				.key_old  (key_old),
				.count    (count),
				.left_id  (l_id),
				.left_pri (l_pri),
				.left_le  (l_le),
				.right_id (r_id),
				.right_pri(r_pri),
				.seen_in  (l_seen),
				.id       (c_id[i]),
				.pri      (c_pri[i]),
				.le       (c_le[i]),
				.seen_out (c_seen[i])
			);
		end
	endgenerate

	// front entry and match flag from the ends of the row
	assign front_id  = c_id[0];
	assign front_pri = c_pri[0];
	assign found     = c_seen[CAPACITY-1];

endmodule

>>> rtl/stable_priority_queue_with_upgrade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_with_upgrade
// sorted priority queue with stable order, pop, clear and priority upgrade
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per beat: tuser holds the command code
//   (insert, pop front, upgrade, clear), tdata the id and priorities.
//   m_axis returns exactly one result beat per command with the id
//   removed by a pop, the front entry, the count, an empty flag and a status.
//   Entries sit in a row of cells kept in ascending priority order; every
//   cell compares against the command key at once and all cells shift together.
//   The result passes from the command beat through S_DONE into the output
//   register; an upgrade that finds its entry passes through S_UPG first.
//   A new command is taken only once the last one has left S_DONE; a successful
//   upgrade needs a removal pass and then a reinsertion pass through the row.
//   The result sits in an output register; while the receiver holds
//   m_axis_tready low the finished command waits in S_DONE and no further
//   command is taken until its result can be moved into that register.
//   Reset clears the count (queue empty) and the handshake state; entry
//   storage is not cleared, since only entries below the count are read.
// ----------------------------------------------------------------------------
module stable_priority_queue_with_upgrade #(
	parameter int CAPACITY      = spq_pkg::DEF_CAPACITY,
	parameter int ID_BITS       = spq_pkg::DEF_ID_BITS,
	parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// patient_id [15:0], priority_req [31:16], old_priority [47:32]
	input  logic [spq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// command [1:0]
	input  logic [spq_pkg::CMD_W-1:0]        s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// removed_id [15:0], front_id [31:16], front_priority [47:32],
	// queue_count [54:48], queue_empty [55], status [58:56], zero [63:59]
	output logic [spq_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

	`include "stable_priority_queue_with_upgrade_assert.svh"

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// controller states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_UPG  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]                      state_q;
	logic [CNT_W-1:0]                count_q;
	logic [ID_BITS-1:0]              upg_id_q;
	logic [PRIORITY_BITS-1:0]        upg_pri_q;
	logic [ID_BITS-1:0]              removed_q;
	logic [spq_pkg::STATUS_W-1:0]    status_q;
	logic                            m_valid_q;
	logic [spq_pkg::OUT_DATA_W-1:0]  m_data_q;

	logic                            accept;
	logic [spq_pkg::CMD_W-1:0]       cmd;
	logic [ID_BITS-1:0]              in_id;
	logic [PRIORITY_BITS-1:0]        in_pri;
	logic [PRIORITY_BITS-1:0]        in_old;
	logic [ID_BITS-1:0]              key_id;
	logic [PRIORITY_BITS-1:0]        key_pri;
	logic                            full;
	logic                            empty;
	logic                            urgent;
	logic                            found;
	logic [ID_BITS-1:0]              front_id;
	logic [PRIORITY_BITS-1:0]        front_pri;
	logic                            out_free;
	spq_pkg::spq_ctl_t               ctl;

	// input beat fields at internal widths
	assign accept = s_axis_tvalid && s_axis_tready;
	assign cmd    = s_axis_tuser;
	assign in_id  = ID_BITS'(s_axis_tdata[15:0]);
	assign in_pri = PRIORITY_BITS'(s_axis_tdata[31:16]);
	assign in_old = PRIORITY_BITS'(s_axis_tdata[47:32]);

	assign s_axis_tready = (state_q == S_IDLE);
	assign full          = (count_q == CNT_W'(CAPACITY));
	assign empty         = (count_q == '0);
	assign urgent        = (in_pri < in_old);
	assign out_free      = !m_valid_q || m_axis_tready;

	// key into the row: the beat, or the held entry during reinsertion
	assign key_id  = (state_q == S_UPG) ? upg_id_q : in_id;
	assign key_pri = (state_q == S_UPG) ? upg_pri_q : in_pri;

	// row control
	always_comb begin
		ctl.insert     = (state_q == S_UPG) ||
		                 (accept && (cmd == spq_pkg::CMD_INSERT) && !full);
		ctl.remove     = accept && (cmd == spq_pkg::CMD_UPGRADE) && urgent;
		ctl.remove_all = accept && (cmd == spq_pkg::CMD_POP) && !empty;
	end

	spq_chain #(
		.CAPACITY     (CAPACITY),
		.ID_BITS      (ID_BITS),
		.PRIORITY_BITS(PRIORITY_BITS),
		.CNT_W        (CNT_W)
	) u_chain (
		.clk      (clk),
		.ctl      (ctl),
		.key_id   (key_id),
		.key_pri  (key_pri),
		.key_old  (in_old),
		.count    (count_q),
		.front_id (front_id),
		.front_pri(front_pri),
		.found    (found)
	);

	// sequencer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DONE;
						unique case (cmd)
							spq_pkg::CMD_INSERT: begin
								if (!full) count_q <= count_q + CNT_W'(1);
							end
							spq_pkg::CMD_POP: begin
								if (!empty) count_q <= count_q - CNT_W'(1);
							end
							spq_pkg::CMD_UPGRADE: begin
								if (urgent && found) begin
									count_q <= count_q - CNT_W'(1);
									state_q <= S_UPG;
								end
							end
							spq_pkg::CMD_CLEAR: begin
								count_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_UPG: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-command result fields and upgrade key
	always_ff @(posedge clk) begin
		if (accept) begin
			upg_id_q  <= in_id;
			upg_pri_q <= in_pri;
			removed_q <= '0;
			status_q  <= spq_pkg::ST_OK;
			unique case (cmd)
				spq_pkg::CMD_INSERT: begin
					if (full) status_q <= spq_pkg::ST_FULL;
				end
				spq_pkg::CMD_POP: begin
					if (empty) status_q <= spq_pkg::ST_EMPTY;
					else removed_q <= front_id;
				end
				spq_pkg::CMD_UPGRADE: begin
					if (!urgent) status_q <= spq_pkg::ST_NOT_URGENT;
					else if (!found) status_q <= spq_pkg::ST_ABSENT;
				end
				spq_pkg::CMD_CLEAR: ;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			m_data_q <= {5'b0,
			             status_q,
			             empty,
			             spq_pkg::QCOUNT_W'(count_q),
			             empty ? 16'd0 : spq_pkg::FIELD_W'(front_pri),
			             empty ? 16'd0 : spq_pkg::FIELD_W'(front_id),
			             spq_pkg::FIELD_W'(removed_q)};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// checks
	`SPQ_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`SPQ_ASSERT_NXT(a_one_in_flight, accept, !s_axis_tready, "beat taken while busy")
	`SPQ_ASSERT_IMP(a_upg_follows, state_q == S_UPG, $past(accept), "reinsertion without upgrade beat")
	`SPQ_ASSERT_IMP(a_out_source, $rose(m_valid_q), $past(state_q == S_DONE), "result from nowhere")
	`SPQ_ASSERT_IMP(a_empty_flag, m_valid_q, m_data_q[55] == (m_data_q[54:48] == 7'd0), "empty flag off count")

endmodule
